FILE: rtl/core/iidl_pkg.sv
// Shared types and codes for the indexed insert/delete list.
// No dependencies; used by iidl_cell and indexed_insert_delete_list.
`default_nettype none
package iidl_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned PosW   = 5;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned StatW  = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    logic ins;
    logic ers;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/core/iidl_cell.sv
// One storage cell of the list chain: holds one word, shifts up or down.
// Depends on iidl_pkg for the word width and the control struct.
`default_nettype none
module iidl_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned PW    = 5
) (
  input  wire logic                              clk_i,
  input  wire iidl_pkg::cell_ctrl_t              ctrl_i,
  input  wire logic [PW-1:0]                     pos_i,
  input  wire logic signed [iidl_pkg::WordW-1:0] word_i,
  input  wire logic signed [iidl_pkg::WordW-1:0] left_i,
  input  wire logic signed [iidl_pkg::WordW-1:0] right_i,
  output logic signed [iidl_pkg::WordW-1:0]      value_o,
  output logic signed [iidl_pkg::WordW-1:0]      rd_o
);

  logic signed [iidl_pkg::WordW-1:0] value_q, value_d;
  logic                              hit, above;

  assign hit   = (pos_i == PW'(INDEX));
  assign above = (PW'(INDEX) > pos_i);

  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins) begin
      if (hit) begin
        value_d = word_i;
      end else if (above) begin
        value_d = left_i;
      end
    end else if (ctrl_i.ers) begin
      if (hit || above) begin
        value_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign rd_o    = hit ? value_q : '0;

endmodule
`default_nettype wire

FILE: rtl/core/indexed_insert_delete_list.sv
// Indexed insert/delete list: a chain of DEPTH word cells plus a fill count.
// Result item: registered, presented in the cycle after the input item is accepted.
// Throughput: one item per cycle for every command while the output is not stalled; all cells shift in parallel.
// Reset: fill count cleared, output register empty; cell contents undefined.
// Depends on iidl_pkg and iidl_cell.
`default_nettype none
module indexed_insert_delete_list #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [4:0] position, [36:5] word_in, [39:37] zero
  input  wire logic [39:0] s_tdata,
  // [2:0] command
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [31:0] word_out, [36:32] fill_count, [38:37] status, [39] zero
  output logic [39:0]      m_tdata
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > iidl_pkg::PosW) ? CW : iidl_pkg::PosW;
  localparam int unsigned WW = iidl_pkg::WordW;

  logic                 accept;
  iidl_pkg::cmd_e       cmd;
  logic [PW-1:0]        pos;
  logic [PW-1:0]        cnt_ext;
  logic signed [WW-1:0] word;

  logic [CW-1:0]        count_q, count_d;
  logic                 out_valid_q;
  logic signed [WW-1:0] word_out_q, word_out_d;
  logic [CW-1:0]        fill_q;
  iidl_pkg::status_e    status_q, status_d;

  iidl_pkg::cell_ctrl_t ctrl;
  logic [PW-1:0]        sel_pos;
  logic                 full, empty;

  logic signed [WW-1:0] values [DEPTH];
  logic signed [WW-1:0] rds    [DEPTH];
  logic signed [WW-1:0] rd_word;

  assign cmd     = iidl_pkg::cmd_e'(s_tuser);
  assign pos     = PW'(s_tdata[4:0]);
  assign word    = s_tdata[36:5];
  assign cnt_ext = PW'(count_q);
  assign full    = (count_q == CW'(DEPTH));
  assign empty   = (count_q == '0);

  assign s_tready = !out_valid_q || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | rds[i];
    end
  end

  always_comb begin
    ctrl       = '0;
    sel_pos    = pos;
    count_d    = count_q;
    status_d   = iidl_pkg::ST_OK;
    word_out_d = '0;
    unique case (cmd)
      iidl_pkg::CMD_APPEND: begin
        sel_pos = cnt_ext;
        if (full) begin
          status_d = iidl_pkg::ST_FULL;
        end else begin
          ctrl.ins = 1'b1;
          count_d  = count_q + 1'b1;
        end
      end
      iidl_pkg::CMD_REMOVE: begin
        if (empty) begin
          status_d = iidl_pkg::ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      iidl_pkg::CMD_INSERT: begin
        if (full) begin
          status_d = iidl_pkg::ST_FULL;
        end else if (pos > cnt_ext) begin
          status_d = iidl_pkg::ST_RANGE;
        end else begin
          ctrl.ins = 1'b1;
          count_d  = count_q + 1'b1;
        end
      end
      iidl_pkg::CMD_ERASE: begin
        if (empty) begin
          status_d = iidl_pkg::ST_EMPTY;
        end else if (pos >= cnt_ext) begin
          status_d = iidl_pkg::ST_RANGE;
        end else begin
          ctrl.ers = 1'b1;
          count_d  = count_q - 1'b1;
        end
      end
      iidl_pkg::CMD_READ: begin
        if (empty) begin
          status_d = iidl_pkg::ST_EMPTY;
        end else if (pos >= cnt_ext) begin
          status_d = iidl_pkg::ST_RANGE;
        end else begin
          word_out_d = rd_word;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      ctrl = '0;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [WW-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = word;
    end else begin : g_mid
      assign left = values[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = values[g];
    end else begin : g_inner
      assign right = values[g+1];
    end
    iidl_cell #(
      .INDEX(g),
      .PW   (PW)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .pos_i  (sel_pos),
      .word_i (word),
      .left_i (left),
      .right_i(right),
      .value_o(values[g]),
      .rd_o   (rds[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_out_q <= word_out_d;
      fill_q     <= count_d;
      status_q   <= status_d;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {1'b0, status_q, 5'(fill_q), word_out_q};

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count above depth");

  a_append_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd == iidl_pkg::CMD_APPEND && !full |=> count_q == $past(count_q) + 1'b1)
    else $error("append did not grow the list");

  a_full_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd == iidl_pkg::CMD_APPEND && full |=> status_q == iidl_pkg::ST_FULL)
    else $error("append to full list not flagged");

  a_word_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && word_out_q != '0 |-> status_q == iidl_pkg::ST_OK)
    else $error("word returned with error status");

  a_fill_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> fill_q == count_q)
    else $error("reported fill count differs from list count");

endmodule
`default_nettype wire

FILE: dv/indexed_insert_delete_list_tb.sv
// Self-checking testbench for indexed_insert_delete_list: directed and random command items
// on the input stream, checked against a shadow copy of the list kept in a scoreboard class.
// Depends on iidl_pkg and the indexed_insert_delete_list RTL.
`default_nettype none
module indexed_insert_delete_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 16;
  localparam logic [iidl_pkg::CmdW-1:0] CMD_TOP = {iidl_pkg::CmdW{1'b1}};

  typedef struct {
    logic [iidl_pkg::WordW-1:0] word_out;
    logic [iidl_pkg::PosW-1:0]  fill_count;
    iidl_pkg::status_e          status;
  } list_reply_t;

  class list_shadow;
    logic [iidl_pkg::WordW-1:0] words [DEPTH];
    int unsigned                used_count;
    list_reply_t                replies_due [$];
    int unsigned                mismatches;

    function new();
      used_count = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction

    function void note_command(logic [iidl_pkg::CmdW-1:0] cmd, logic [iidl_pkg::PosW-1:0] pos,
                               logic [iidl_pkg::WordW-1:0] word);
      list_reply_t r;
      r.word_out = '0;
      r.status   = iidl_pkg::ST_OK;
      case (cmd)
        iidl_pkg::CMD_APPEND: begin
          if (used_count >= DEPTH) r.status = iidl_pkg::ST_FULL;
          else begin
            words[used_count] = word;
            used_count++;
          end
        end
        iidl_pkg::CMD_REMOVE: begin
          if (used_count == 0) r.status = iidl_pkg::ST_EMPTY;
          else used_count--;
        end
        iidl_pkg::CMD_INSERT: begin
          if (used_count >= DEPTH) r.status = iidl_pkg::ST_FULL;
          else if (pos > used_count) r.status = iidl_pkg::ST_RANGE;
          else begin
            for (int unsigned i = used_count; i > pos; i--) words[i] = words[i-1];
            words[pos] = word;
            used_count++;
          end
        end
        iidl_pkg::CMD_ERASE: begin
          if (used_count == 0) r.status = iidl_pkg::ST_EMPTY;
          else if (pos >= used_count) r.status = iidl_pkg::ST_RANGE;
          else begin
            for (int unsigned i = pos; i + 1 < used_count; i++) words[i] = words[i+1];
            used_count--;
          end
        end
        iidl_pkg::CMD_READ: begin
          if (used_count == 0) r.status = iidl_pkg::ST_EMPTY;
          else if (pos >= used_count) r.status = iidl_pkg::ST_RANGE;
          else r.word_out = words[pos];
        end
        default: ;
      endcase
      r.fill_count = used_count[iidl_pkg::PosW-1:0];
      replies_due = {replies_due, r};
    endfunction

    function void check_reply(logic [39:0] data);
      list_reply_t r;
      if (replies_due.size() == 0) begin
        $error("unexpected result item %h", data);
        mismatches++;
        return;
      end
      r = replies_due.pop_front();
      if (data[31:0] !== r.word_out) begin
        $error("word_out: expected %h, got %h", r.word_out, data[31:0]);
        mismatches++;
      end
      if (data[36:32] !== r.fill_count) begin
        $error("fill_count: expected %0d, got %0d", r.fill_count, data[36:32]);
        mismatches++;
      end
      if (data[38:37] !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, data[38:37]);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [4:0] position, [36:5] word_in, [39:37] zero
  logic [39:0] s_tdata  = '0;
  // [2:0] command
  logic [2:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [31:0] word_out, [36:32] fill_count, [38:37] status, [39] zero
  logic [39:0] m_tdata;

  list_shadow shadow = new();

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold      = 0;

  indexed_insert_delete_list #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic send_item(input logic [iidl_pkg::CmdW-1:0] cmd,
                           input logic [iidl_pkg::PosW-1:0] pos,
                           input logic [iidl_pkg::WordW-1:0] word);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {3'b000, word, pos};
    do @(posedge clk_i); while (!s_tready);
    shadow.note_command(cmd, pos, word);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk_i);
  endtask

  task automatic random_items(input int count);
    logic [iidl_pkg::CmdW-1:0]  cmd;
    logic [iidl_pkg::PosW-1:0]  pos;
    logic [iidl_pkg::WordW-1:0] word;
    int unsigned                pick;
    bit                         grow;
    grow = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (shadow.used_count == DEPTH && $urandom_range(3) == 0) grow = 1'b0;
      if (shadow.used_count == 0 && $urandom_range(3) == 0) grow = 1'b1;
      if ($urandom_range(29) == 0) grow = !grow;
      pick = $urandom_range(99);
      if (grow) begin
        if (pick < 30) cmd = iidl_pkg::CMD_APPEND;
        else if (pick < 55) cmd = iidl_pkg::CMD_INSERT;
        else if (pick < 62) cmd = iidl_pkg::CMD_REMOVE;
        else if (pick < 72) cmd = iidl_pkg::CMD_ERASE;
        else if (pick < 95) cmd = iidl_pkg::CMD_READ;
        else cmd = iidl_pkg::CmdW'($urandom_range(int'(iidl_pkg::CMD_READ) + 1, int'(CMD_TOP)));
      end else begin
        if (pick < 8) cmd = iidl_pkg::CMD_APPEND;
        else if (pick < 16) cmd = iidl_pkg::CMD_INSERT;
        else if (pick < 40) cmd = iidl_pkg::CMD_REMOVE;
        else if (pick < 70) cmd = iidl_pkg::CMD_ERASE;
        else if (pick < 95) cmd = iidl_pkg::CMD_READ;
        else cmd = iidl_pkg::CmdW'($urandom_range(int'(iidl_pkg::CMD_READ) + 1, int'(CMD_TOP)));
      end
      if ($urandom_range(9) == 0) pos = iidl_pkg::PosW'($urandom_range(31));
      else pos = iidl_pkg::PosW'($urandom_range(shadow.used_count));
      case ($urandom_range(7))
        0: word = 32'h8000_0000;
        1: word = 32'h7fff_ffff;
        2: word = '1;
        3: word = '0;
        default: word = $urandom;
      endcase
      send_item(cmd, pos, word);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_tvalid && m_tready) shadow.check_reply(m_tdata);
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold--;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(iidl_pkg::CMD_READ, 5'd0, 32'h1111_1111);
    send_item(iidl_pkg::CMD_REMOVE, 5'd0, '0);
    send_item(iidl_pkg::CMD_ERASE, 5'd0, '0);
    send_item(iidl_pkg::CMD_INSERT, 5'd1, 32'h2222_2222);
    send_item(iidl_pkg::CMD_INSERT, 5'd0, 32'h8000_0000);
    send_item(iidl_pkg::CMD_APPEND, 5'd0, 32'h7fff_ffff);
    send_item(iidl_pkg::CMD_INSERT, 5'd2, 32'hffff_ffff);
    send_item(iidl_pkg::CMD_INSERT, 5'd1, 32'h0000_0000);
    for (int p = 0; p <= 4; p++) send_item(iidl_pkg::CMD_READ, iidl_pkg::PosW'(p), '0);
    send_item(iidl_pkg::CMD_READ, 5'd31, '0);
    send_item(iidl_pkg::CMD_ERASE, 5'd4, '0);
    send_item(iidl_pkg::CMD_ERASE, 5'd1, '0);
    send_item(iidl_pkg::CMD_ERASE, 5'd2, '0);
    send_item(iidl_pkg::CMD_REMOVE, 5'd0, '0);
    for (int c = int'(iidl_pkg::CMD_READ) + 1; c <= int'(CMD_TOP); c++) begin
      send_item(iidl_pkg::CmdW'(c), iidl_pkg::PosW'($urandom_range(31)), $urandom);
    end
    send_item(iidl_pkg::CMD_APPEND, 5'd0, 32'h1234_5678);
    drain_results();

    rx_hold = 60;
    random_items(140);
    drain_results();

    tx_idle_pct  = 54;
    rx_stall_pct = 0;
    random_items(135);
    drain_results();

    tx_idle_pct  = 0;
    rx_stall_pct = 54;
    random_items(135);
    drain_results();

    tx_idle_pct  = 34;
    rx_stall_pct = 34;
    random_items(140);
    drain_results();

    repeat (5) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
rtl/core/iidl_pkg.sv
rtl/core/iidl_cell.sv
rtl/core/indexed_insert_delete_list.sv
dv/indexed_insert_delete_list_tb.sv
